// ===== rtl/core/apr_pkg.sv =====
package apr_pkg;

	// payload store geometry
	localparam int PAYLOAD_DEPTH = 256;
	localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
	localparam int WPOS_W        = $clog2(PAYLOAD_DEPTH) + 1;

	// frame bytes
	localparam logic [7:0] START_BYTE    = 8'h02;
	localparam logic [7:0] CMD_STORE     = 8'h00;
	localparam logic [7:0] CMD_APPLY     = 8'h02;
	localparam int         BYTES_PER_LED = 9;

	// configuration register indexes
	localparam logic CFG_DEVICE_ID    = 1'b0;
	localparam logic CFG_STRIP_LENGTH = 1'b1;

	// result event codes
	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_STORED      = 3'd1,
		EV_OTHER_ID    = 3'd2,
		EV_APPLY       = 3'd3,
		EV_APPLY_EMPTY = 3'd4,
		EV_CHK_ERR     = 3'd5,
		EV_OVERFLOW    = 3'd6
	} apr_event_t;

	// store write from the parser
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} apr_wr_t;

	// per-byte status from the parser
	typedef struct packed {
		apr_event_t ev;
		logic       payload_ok;
	} apr_stat_t;

endpackage

// ===== rtl/core/apr_ram.sv =====
module apr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/apr_parser.sv =====
module apr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        data_byte,
	input  logic [5:0]        device_id,
	input  logic [4:0]        strip_length,
	output apr_pkg::apr_wr_t   wr,
	output apr_pkg::apr_stat_t stat
);
	import apr_pkg::*;

	localparam logic [2:0] PH_STX  = 3'd0;
	localparam logic [2:0] PH_ID   = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CHK  = 3'd4;

	localparam logic [WPOS_W-1:0] DEPTH_W = WPOS_W'(PAYLOAD_DEPTH);

	logic [2:0]        phase_q, phase_n;
	logic [7:0]        xor_q, xor_n;
	logic [7:0]        target_q, target_n;
	logic              apply_q, apply_n;
	logic [WPOS_W-1:0] wpos_q, wpos_n;
	logic [7:0]        cnt_q, cnt_n;
	logic              ok_q, ok_n;
	logic              match;
	logic [8:0]        cnt_inc;
	logic [8:0]        limit;
	apr_event_t        ev;

	assign match   = (target_q == {2'b00, device_id});
	assign cnt_inc = {1'b0, cnt_q} + 9'd1;
	// strip_length * 9 as shift and add
	assign limit   = {1'b0, strip_length, 3'b000} + {4'b0000, strip_length};

	// next state for one received byte
	always_comb begin
		phase_n   = phase_q;
		xor_n     = xor_q;
		target_n  = target_q;
		apply_n   = apply_q;
		wpos_n    = wpos_q;
		cnt_n     = cnt_q;
		ok_n      = ok_q;
		ev        = EV_NONE;
		wr.en     = 1'b0;
		wr.addr   = ADDR_W'(wpos_q);
		wr.data   = data_byte;
		unique case (phase_q)
			PH_ID: begin
				target_n = data_byte;
				xor_n    = xor_q ^ data_byte;
				phase_n  = PH_CMD;
			end
			PH_CMD: begin
				xor_n  = xor_q ^ data_byte;
				wpos_n = '0;
				if (data_byte == CMD_STORE) begin
					apply_n = 1'b0;
					phase_n = PH_DATA;
				end else if (data_byte == CMD_APPLY) begin
					apply_n = 1'b1;
					phase_n = PH_CHK;
				end else begin
					phase_n = PH_STX;
				end
			end
			PH_DATA: begin
				if (match) begin
					wr.en  = (wpos_q < DEPTH_W);
					wpos_n = wpos_q + WPOS_W'(1);
				end
				xor_n = xor_q ^ data_byte;
				cnt_n = cnt_inc[7:0];
				if (cnt_inc >= limit) begin
					phase_n = PH_CHK;
				end
				// overflow wins over the move to checksum
				if ((wpos_n >= DEPTH_W) || cnt_inc[8]) begin
					phase_n = PH_STX;
					ev      = EV_OVERFLOW;
				end
			end
			PH_CHK: begin
				if (xor_q != data_byte) begin
					ev = EV_CHK_ERR;
				end else if (!apply_q) begin
					if (match) begin
						ok_n = 1'b1;
						ev   = EV_STORED;
					end else begin
						ev = EV_OTHER_ID;
					end
				end else begin
					ev = ok_q ? EV_APPLY : EV_APPLY_EMPTY;
				end
				phase_n = PH_STX;
			end
			default: begin
				phase_n = PH_STX;
				if (data_byte == START_BYTE) begin
					xor_n   = '0;
					wpos_n  = '0;
					cnt_n   = '0;
					phase_n = PH_ID;
				end
			end
		endcase
		if (!step_en) begin
			wr.en = 1'b0;
		end
	end

	assign stat.ev         = step_en ? ev : EV_NONE;
	assign stat.payload_ok = step_en ? ok_n : ok_q;

	// advance parser state on each received byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_STX;
			xor_q    <= '0;
			target_q <= '0;
			apply_q  <= 1'b0;
			wpos_q   <= '0;
			cnt_q    <= '0;
			ok_q     <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_n;
			xor_q    <= xor_n;
			target_q <= target_n;
			apply_q  <= apply_n;
			wpos_q   <= wpos_n;
			cnt_q    <= cnt_n;
			ok_q     <= ok_n;
		end
	end

endmodule

// ===== rtl/core/addressed_packet_receiver.sv =====
// Channel   Dir  Signals                           Beat contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser  one serial byte or one store read
// m_*       out  m_tvalid m_tready m_tdata m_tuser  event, read byte, payload flag
// cfg_*     in   cfg_valid cfg_ready cfg_index ...  device_id (0), strip_length (1)
//
// Every input beat gives one output beat; one beat per cycle is sustained unless
// m_tready stalls. The input register and the output register each hold one beat,
// and the payload store read is the output register stage of read beats.
// A stall on m_tready holds the whole pipe and drops s_tready in the same cycle.
// Reset clears the parser and the pipe valid bits; the payload store is not
// cleared and holds no data until written. cfg_ready is always high.
module addressed_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data_byte[7:0], read_index[15:8]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // read_data[7:0], payload_valid[8], zero[15:9]
	output logic [2:0]  m_tuser,   // event_res[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import apr_pkg::*;

	logic [5:0]  device_id_q;
	logic [4:0]  strip_length_q;

	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  ridx_s1;

	logic        valid_s2;
	logic        rd_s2;
	apr_event_t  ev_s2;
	logic        pv_s2;

	logic        advance;
	logic        step_en;
	logic        in_range;
	logic        rd_en;
	logic [7:0]  ram_dout;
	apr_wr_t     wr;
	apr_stat_t   stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q    <= '0;
			strip_length_q <= 5'd5;
		end else if (cfg_valid) begin
			unique case (cfg_index[0])
				CFG_DEVICE_ID:    device_id_q    <= cfg_data;
				CFG_STRIP_LENGTH: strip_length_q <= cfg_data[4:0];
				default:          ;
			endcase
		end
	end

	// the pipe moves whenever the output register is free or drained
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = advance;

	assign step_en  = advance && valid_s1 && !func_s1;
	assign in_range = (int'(ridx_s1) < PAYLOAD_DEPTH);
	assign rd_en    = advance && valid_s1 && func_s1 && in_range;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			func_s1 <= s_tuser[0];
			byte_s1 <= s_tdata[7:0];
			ridx_s1 <= s_tdata[15:8];
		end
	end

	apr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.data_byte    (byte_s1),
		.device_id    (device_id_q),
		.strip_length (strip_length_q),
		.wr           (wr),
		.stat         (stat)
	);

	apr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_en),
		.rd_addr (ADDR_W'(ridx_s1)),
		.rd_data (ram_dout)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rd_s2 <= func_s1 && in_range;
			ev_s2 <= stat.ev;
			pv_s2 <= stat.payload_ok;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2;
	assign m_tdata  = {7'b0000000, pv_s2, rd_s2 ? ram_dout : 8'h00};

endmodule

// ===== rtl/core/apr_checker.sv =====
module apr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import apr_pkg::*;

	logic seen_pv_q;

	// remember that a beat has shown payload valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_pv_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[8]) begin
			seen_pv_q <= 1'b1;
		end
	end

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	// payload valid never drops once shown
	a_pv_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_pv_q |-> m_tdata[8])
		else $error("payload valid dropped");

	// a stored event comes with payload valid
	a_stored_pv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_STORED) |-> m_tdata[8])
		else $error("stored event without payload valid");

	// parser events carry no read byte
	a_ev_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != EV_NONE) |-> (m_tdata[7:0] == 8'h00) && (m_tdata[15:9] == 7'd0))
		else $error("read byte on a parser event");

endmodule

bind addressed_packet_receiver apr_checker u_apr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
